>>> design/assert_macros.svh
// Assertion macros used by the top-level RTL file of the page mapping table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define ASSERT_CLK(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

>>> design/pmt_pkg.sv
// Shared types, codes and defaults of the page mapping table.
`timescale 1ns / 1ps

package pmt_pkg;

    // Field widths fixed by the interface
    localparam int CFG_BITS       = 11;
    localparam int CFG_INDEX_BITS = 2;
    localparam int ACTION_BITS    = 3;
    localparam int STATUS_BITS    = 2;

    // Parameter defaults
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_VALUE_BITS  = 64;

    // Configuration register reset values
    localparam logic [CFG_BITS-1:0] TABLE_SIZE_RESET = CFG_BITS'(1024);
    localparam logic [CFG_BITS-1:0] RESERVED_RESET   = CFG_BITS'(0);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TABLE_SIZE = 2'd0,
        REG_RESERVED   = 2'd1
    } cfg_reg_t;

    // Action codes; codes five to seven do nothing
    typedef enum logic [ACTION_BITS-1:0] {
        ACT_ALLOC   = 3'd0,
        ACT_RECYCLE = 3'd1,
        ACT_LOOKUP  = 3'd2,
        ACT_INSTALL = 3'd3,
        ACT_CAS     = 3'd4
    } action_t;

    // Result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_RANGE    = 2'd2,
        ST_MISMATCH = 2'd3
    } status_t;

endpackage

>>> design/page_id_mapping_table.sv
// Top level of the page mapping table: id allocator, entry RAM and free-id stack.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------------
//  in      | in_valid / in_stall    | action, page_id, expected_value, new_value
//  out     | out_valid / out_stall  | status, given_id, read_value
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each item passes through S_IDLE and S_BUSY: the entry RAM and the stack RAM are
// read when the item is accepted in S_IDLE, and the result is formed and written
// back in S_BUSY. No new item is taken until the current one has completed.
// A finished result waits in the output register; the next item is accepted
// meanwhile, but its completion waits while out_stall holds that register.
// Reset clears control state only; RAM contents are undefined until written.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module page_id_mapping_table #(
    parameter int TABLE_DEPTH = pmt_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_BITS  = pmt_pkg::DEF_VALUE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pmt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pmt_pkg::CFG_BITS-1:0]        cfg_data,
    // Request items
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [pmt_pkg::ACTION_BITS-1:0]     action,
    input  logic [$clog2(TABLE_DEPTH)-1:0]      page_id,
    input  logic [VALUE_BITS-1:0]               expected_value,
    input  logic [VALUE_BITS-1:0]               new_value,
    // Result items
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pmt_pkg::STATUS_BITS-1:0]     status,
    output logic [$clog2(TABLE_DEPTH)-1:0]      given_id,
    output logic [VALUE_BITS-1:0]               read_value
);

    import pmt_pkg::*;

    localparam int ID_BITS   = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);
    localparam int WIDE_BITS = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;

    localparam logic [CNT_BITS-1:0]  DEPTH_CNT  = CNT_BITS'(TABLE_DEPTH);
    localparam logic [WIDE_BITS-1:0] DEPTH_WIDE = WIDE_BITS'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } state_t;

    // Control and payload registers
    state_t                  state_reg, state_next;
    logic [CFG_BITS-1:0]     table_size_reg;
    logic [CFG_BITS-1:0]     next_fresh_reg, next_fresh_next;
    logic [CNT_BITS-1:0]     free_count_reg, free_count_next;

    logic [ACTION_BITS-1:0]  act_reg;
    logic [ID_BITS-1:0]      pid_reg;
    logic [VALUE_BITS-1:0]   exp_reg;
    logic [VALUE_BITS-1:0]   new_reg;

    logic                    out_valid_reg;
    logic [STATUS_BITS-1:0]  status_reg;
    logic [ID_BITS-1:0]      given_reg;
    logic [VALUE_BITS-1:0]   read_reg;

    // Datapath signals
    logic                    in_accept;
    logic                    cfg_we;
    logic                    done;
    logic [WIDE_BITS-1:0]    table_size_wide;
    logic [WIDE_BITS-1:0]    lim;
    logic [WIDE_BITS-1:0]    pid_wide;
    logic [WIDE_BITS-1:0]    fresh_wide;
    logic                    pid_ok;
    logic [CNT_BITS-1:0]     stack_top;

    logic [VALUE_BITS-1:0]   entry_rd;
    logic                    entry_we;
    logic [ID_BITS-1:0]      stack_rd;
    logic                    stack_we;

    status_t                 status_calc;
    logic [ID_BITS-1:0]      given_calc;
    logic [VALUE_BITS-1:0]   read_calc;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid & ~in_stall;
    assign done      = (state_reg == S_BUSY) & (~out_valid_reg | ~out_stall);

    // Bound in force and range checks
    assign table_size_wide = WIDE_BITS'(table_size_reg);
    assign lim        = (table_size_wide < DEPTH_WIDE) ? table_size_wide : DEPTH_WIDE;
    assign pid_wide   = WIDE_BITS'(pid_reg);
    assign fresh_wide = WIDE_BITS'(next_fresh_reg);
    assign pid_ok     = pid_wide < lim;
    assign stack_top  = free_count_reg - CNT_BITS'(1);

    // Entry store
    pmt_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (page_id),
        .rd_data (entry_rd),
        .wr_en   (entry_we),
        .wr_addr (pid_reg),
        .wr_data (new_reg)
    );

    // Free-id stack; the top entry is read at accept for a possible pop
    pmt_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (stack_top[ID_BITS-1:0]),
        .rd_data (stack_rd),
        .wr_en   (stack_we),
        .wr_addr (free_count_reg[ID_BITS-1:0]),
        .wr_data (pid_reg)
    );

    // Result and state update of the item in flight
    always_comb
    begin
        status_calc     = ST_OK;
        given_calc      = '0;
        read_calc       = '0;
        entry_we        = 1'b0;
        stack_we        = 1'b0;
        free_count_next = free_count_reg;
        next_fresh_next = next_fresh_reg;
        case (act_reg)
            ACT_ALLOC:
            begin
                if (free_count_reg != '0)
                begin
                    free_count_next = stack_top;
                    given_calc      = stack_rd;
                end
                else if (fresh_wide < lim)
                begin
                    given_calc      = fresh_wide[ID_BITS-1:0];
                    next_fresh_next = next_fresh_reg + CFG_BITS'(1);
                end
                else
                begin
                    status_calc = ST_NO_FREE;
                end
            end
            ACT_RECYCLE:
            begin
                if (!pid_ok)
                begin
                    status_calc = ST_RANGE;
                end
                else if (free_count_reg < DEPTH_CNT)
                begin
                    stack_we        = 1'b1;
                    free_count_next = free_count_reg + CNT_BITS'(1);
                end
            end
            ACT_LOOKUP:
            begin
                if (!pid_ok)
                begin
                    status_calc = ST_RANGE;
                end
                else
                begin
                    read_calc = entry_rd;
                end
            end
            ACT_INSTALL:
            begin
                if (!pid_ok)
                begin
                    status_calc = ST_RANGE;
                end
                else
                begin
                    entry_we = 1'b1;
                end
            end
            ACT_CAS:
            begin
                if (!pid_ok)
                begin
                    status_calc = ST_RANGE;
                end
                else if (entry_rd == exp_reg)
                begin
                    entry_we  = 1'b1;
                    read_calc = new_reg;
                end
                else
                begin
                    status_calc = ST_MISMATCH;
                    read_calc   = entry_rd;
                end
            end
            default:
            begin
                status_calc = ST_OK;
            end
        endcase
        // Writes and counter moves only when the item completes
        if (!done)
        begin
            entry_we        = 1'b0;
            stack_we        = 1'b0;
            free_count_next = free_count_reg;
            next_fresh_next = next_fresh_reg;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_BUSY;
                end
            end
            S_BUSY:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers; a write of the reserved count reloads the fresh counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            table_size_reg <= TABLE_SIZE_RESET;
            next_fresh_reg <= RESERVED_RESET;
            free_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            next_fresh_reg <= next_fresh_next;
            if (cfg_we && cfg_index == REG_TABLE_SIZE)
            begin
                table_size_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_RESERVED)
            begin
                next_fresh_reg <= cfg_data;
            end
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item capture and output payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg <= action;
            pid_reg <= page_id;
            exp_reg <= expected_value;
            new_reg <= new_value;
        end
        if (done)
        begin
            status_reg <= status_calc;
            given_reg  <= given_calc;
            read_reg   <= read_calc;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign given_id   = given_reg;
    assign read_value = read_reg;

    // Checks
    `ASSERT_NEVER(a_free_count_bound, clk, rst_n, free_count_reg > DEPTH_CNT,
        "free-id count above table depth")
    `ASSERT_CLK(a_done_shows_result, clk, rst_n, done |=> out_valid_reg,
        "completed item not presented")
    `ASSERT_CLK(a_given_only_on_ok, clk, rst_n,
        (out_valid_reg && status_reg != ST_OK) |-> (given_reg == '0),
        "id handed out with error status")
    `ASSERT_CLK(a_fresh_moves_on_alloc, clk, rst_n,
        (next_fresh_reg != $past(next_fresh_reg) && !$past(cfg_we)) |->
            ($past(done) && $past(act_reg) == ACT_ALLOC),
        "fresh id counter moved without allocation")

endmodule

>>> design/pmt_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module pmt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> tb/sv/tb_page_id_mapping_table.sv
// Self-checking testbench for the page id mapping table: allocator, free stack and entries.
`timescale 1ns / 1ps

module tb_page_id_mapping_table;
    import pmt_pkg::*;

    localparam int DEPTH      = DEF_TABLE_DEPTH;
    localparam int ID_BITS    = $clog2(DEPTH);
    localparam int VBITS      = DEF_VALUE_BITS;
    localparam int IDLE_PCT   = 32;
    localparam int STALL_LIMIT = 4000;

    // Register indexes with no register behind them, and the unused action codes
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;
    localparam int ACT_UNUSED_FIRST = 5;
    localparam int ACT_UNUSED_LAST  = 7;

    typedef struct {
        logic [STATUS_BITS-1:0] st;
        logic [ID_BITS-1:0]     id;
        logic [VBITS-1:0]       val;
    } map_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]       cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [ACTION_BITS-1:0]    action;
    logic [ID_BITS-1:0]        page_id;
    logic [VBITS-1:0]          expected_value;
    logic [VBITS-1:0]          new_value;
    logic                      out_valid;
    logic                      out_stall;
    logic [STATUS_BITS-1:0]    status;
    logic [ID_BITS-1:0]        given_id;
    logic [VBITS-1:0]          read_value;

    // Mirror of the block state
    logic [VBITS-1:0]   map_value [DEPTH];
    bit                 map_written [DEPTH];
    logic [ID_BITS-1:0] free_ids [DEPTH];
    int                 free_depth;
    int                 fresh_next;
    int                 cur_table_size;

    // Stimulus bookkeeping
    int          mapped_ids [$];
    int          live_ids [$];
    map_result_t pending_results [$];
    int          errors;
    bit          idle_on;

    page_id_mapping_table uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .page_id        (page_id),
        .expected_value (expected_value),
        .new_value      (new_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .given_id       (given_id),
        .read_value     (read_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int id_limit();
        return (cur_table_size < DEPTH) ? cur_table_size : DEPTH;
    endfunction

    task automatic flag_mismatch(input string what, input logic [VBITS-1:0] got,
                                 input logic [VBITS-1:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Predict one item's result and advance the mirrored state
    task automatic apply_request(input logic [ACTION_BITS-1:0] act,
                                 input logic [ID_BITS-1:0] pid,
                                 input logic [VBITS-1:0] cmp_val,
                                 input logic [VBITS-1:0] new_val,
                                 output map_result_t r);
        int lim;
        lim = id_limit();
        r.st = ST_OK;
        r.id = '0;
        r.val = '0;
        if (act == ACT_ALLOC)
        begin
            if (free_depth > 0)
            begin
                free_depth--;
                r.id = free_ids[free_depth];
            end
            else if (fresh_next < lim)
            begin
                r.id = ID_BITS'(fresh_next);
                fresh_next++;
            end
            else
                r.st = ST_NO_FREE;
            if (r.st == ST_OK)
                live_ids.push_back(int'(r.id));
        end
        else if (act >= ACT_RECYCLE && act <= ACT_CAS)
        begin
            if (int'(pid) >= lim)
                r.st = ST_RANGE;
            else if (act == ACT_RECYCLE)
            begin
                // a full stack only happens after double recycles; push is dropped
                if (free_depth < DEPTH)
                begin
                    free_ids[free_depth] = pid;
                    free_depth++;
                end
            end
            else if (act == ACT_LOOKUP)
                r.val = map_value[pid];
            else
            begin
                if (act == ACT_INSTALL || map_value[pid] == cmp_val)
                    map_value[pid] = new_val;
                else
                    r.st = ST_MISMATCH;
                if (act == ACT_CAS)
                    r.val = map_value[pid];
                if (!map_written[pid])
                begin
                    map_written[pid] = 1'b1;
                    mapped_ids.push_back(int'(pid));
                end
            end
        end
    endtask

    // Drive one request item and hold it until accepted
    task automatic send_item(input logic [ACTION_BITS-1:0] act,
                             input logic [ID_BITS-1:0] pid,
                             input logic [VBITS-1:0] cmp_val,
                             input logic [VBITS-1:0] new_val);
        map_result_t want;
        if (idle_on)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid       <= 1'b1;
        action         <= act;
        page_id        <= pid;
        expected_value <= cmp_val;
        new_value      <= new_val;
        apply_request(act, pid, cmp_val, new_val, want);
        pending_results.push_back(want);
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    // Drop valid and wait for every outstanding result to drain
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        if (idx == REG_TABLE_SIZE)
            cur_table_size = int'(val);
        else if (idx == REG_RESERVED)
            fresh_next = int'(val);
    endtask

    function automatic logic [VBITS-1:0] rand_value();
        return {$urandom, $urandom};
    endfunction

    // Mostly an id already handed out; otherwise any id below the bound, or any id when the bound is zero
    function automatic logic [ID_BITS-1:0] pick_live(input int lim);
        if (live_ids.size() > 0 && $urandom_range(99) < 80)
            return ID_BITS'(live_ids[$urandom_range(live_ids.size() - 1)]);
        if (lim > 0)
            return ID_BITS'($urandom_range(lim - 1));
        return ID_BITS'($urandom);
    endfunction

    // An id below the bound whose entry has been written; never an unwritten one
    function automatic bit pick_mapped(input int lim, output logic [ID_BITS-1:0] pid);
        int k;
        int cand;
        pid = '0;
        for (k = 0; k < 8; k++)
        begin
            if (mapped_ids.size() == 0)
                return 1'b0;
            cand = mapped_ids[$urandom_range(mapped_ids.size() - 1)];
            if (cand < lim)
            begin
                pid = ID_BITS'(cand);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // One random item, mostly lifecycles of allocated ids
    task automatic random_request();
        int lim;
        int roll;
        int k;
        logic [ACTION_BITS-1:0] act;
        logic [ID_BITS-1:0] pid;
        logic [VBITS-1:0] cmp_val;
        logic [VBITS-1:0] new_val;
        lim     = id_limit();
        roll    = $urandom_range(99);
        cmp_val = rand_value();
        new_val = rand_value();
        pid     = ID_BITS'($urandom);
        act     = ACT_ALLOC;
        if (roll < 40 && roll >= 22)
        begin
            act = ACT_INSTALL;
            pid = pick_live(lim);
        end
        else if (roll >= 40 && roll < 78)
        begin
            act = (roll < 60) ? ACT_LOOKUP : ACT_CAS;
            if (!pick_mapped(lim, pid))
            begin
                act = ACT_INSTALL;
                pid = pick_live(lim);
            end
            else if (act == ACT_CAS && $urandom_range(99) < 70)
                cmp_val = map_value[pid];
        end
        else if (roll >= 78 && roll < 90)
        begin
            act = ACT_RECYCLE;
            if (live_ids.size() > 0 && $urandom_range(99) < 85)
            begin
                k   = $urandom_range(live_ids.size() - 1);
                pid = ID_BITS'(live_ids[k]);
                live_ids.delete(k);
            end
            else
                pid = pick_live(lim);
        end
        else if (roll >= 90 && roll < 96)
        begin
            // out of range: nothing is read, so any action is safe
            if (lim < DEPTH)
            begin
                act = ACTION_BITS'($urandom_range(ACT_RECYCLE, ACT_CAS));
                pid = ID_BITS'($urandom_range(lim, DEPTH - 1));
            end
            else
                act = ACT_RECYCLE;
        end
        else if (roll >= 96)
            act = ACTION_BITS'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
        send_item(act, pid, cmp_val, new_val);
    endtask

    // Extremes, every action, double recycle, unknown actions, zero size, stale ids
    task automatic test_directed();
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '0);
        send_item(ACT_ALLOC, '0, '0, '0);
        send_item(ACT_ALLOC, '1, '1, '1);
        send_item(ACT_INSTALL, ID_BITS'(0), '0, '1);
        send_item(ACT_INSTALL, '1, '1, '0);
        send_item(ACT_LOOKUP, ID_BITS'(0), '0, '0);
        send_item(ACT_LOOKUP, '1, '0, '0);
        send_item(ACT_CAS, ID_BITS'(0), '1, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(ACT_CAS, ID_BITS'(0), '0, 64'h5555_5555_5555_5555);
        send_item(ACT_RECYCLE, ID_BITS'(1), '0, '0);
        send_item(ACT_RECYCLE, ID_BITS'(1), '0, '0);
        send_item(ACT_ALLOC, '0, '0, '0);
        send_item(ACT_ALLOC, '0, '0, '0);
        send_item(ACT_ALLOC, '0, '0, '0);
        send_item(ACTION_BITS'(ACT_UNUSED_FIRST), '1, '1, '1);
        send_item(ACTION_BITS'(ACT_UNUSED_LAST), '0, '0, '0);

        // zero table size: all ids out of range, allocation exhausted
        write_reg(REG_TABLE_SIZE, '0);
        send_item(ACT_ALLOC, '0, '0, '0);
        send_item(ACT_LOOKUP, ID_BITS'(0), '0, '0);
        send_item(ACT_INSTALL, '1, '0, '1);
        send_item(ACT_RECYCLE, ID_BITS'(0), '0, '0);

        // id pushed while in range comes back after the bound drops below it
        write_reg(REG_TABLE_SIZE, CFG_BITS'(2));
        write_reg(REG_RESERVED, CFG_BITS'(2));
        send_item(ACT_RECYCLE, ID_BITS'(1), '0, '0);
        write_reg(REG_TABLE_SIZE, CFG_BITS'(1));
        send_item(ACT_ALLOC, '0, '0, '0);
        send_item(ACT_LOOKUP, ID_BITS'(1), '0, '0);
        send_item(ACT_INSTALL, ID_BITS'(1), '0, '1);

        // size above the depth clamps; reserved at the depth exhausts at once
        write_reg(REG_TABLE_SIZE, '1);
        write_reg(REG_RESERVED, CFG_BITS'(DEPTH));
        send_item(ACT_ALLOC, '0, '0, '0);
    endtask

    // Random traffic over a range of table settings
    task automatic test_random_mix();
        int sizes [7]  = '{1024, 16, 1024, 2047, 1, 600, 1024};
        int resv [7]   = '{0, 4, 1000, 1020, 0, 3, 2047};
        int counts [7] = '{90, 80, 70, 60, 50, 90, 60};
        int p;
        int n;
        for (p = 0; p < 7; p++)
        begin
            write_reg(REG_TABLE_SIZE, CFG_BITS'(sizes[p]));
            write_reg(REG_RESERVED, CFG_BITS'(resv[p]));
            // one phase runs flat out on both sides
            idle_on = (p != 5);
            for (n = 0; n < counts[p]; n++)
                random_request();
        end
        idle_on = 1'b1;
    endtask

    // Result checker with random back-pressure
    initial
    begin
        map_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (out_valid === 1'b1 && out_stall === 1'b0)
                begin
                    if (pending_results.size() == 0)
                        flag_mismatch("result with nothing pending", VBITS'(status), '0);
                    else
                    begin
                        want = pending_results.pop_front();
                        if (status !== want.st)
                            flag_mismatch("status", VBITS'(status), VBITS'(want.st));
                        if (given_id !== want.id)
                            flag_mismatch("given_id", VBITS'(given_id), VBITS'(want.id));
                        if (read_value !== want.val)
                            flag_mismatch("read_value", read_value, want.val);
                    end
                end
                out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Watchdog on cycles with no transfer on any channel
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        action         <= '0;
        page_id        <= '0;
        expected_value <= '0;
        new_value      <= '0;
        out_stall      <= 1'b0;
        errors         = 0;
        idle_on        = 1'b1;
        free_depth     = 0;
        cur_table_size = int'(TABLE_SIZE_RESET);
        fresh_next     = int'(RESERVED_RESET);
        foreach (map_written[i])
            map_written[i] = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_random_mix();

        settle();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
